FILE: rtl/sdp_pkg.sv
// Shared types and constants for the stereo disparity to point block.
package sdp_pkg;
  localparam int MaxDisp = 128;
  localparam int WinAw = $clog2(MaxDisp);
  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);
  localparam int DivW = 64;

  // Register indexes
  localparam logic [2:0] RegFocalX = 3'd0;
  localparam logic [2:0] RegFocalY = 3'd1;
  localparam logic [2:0] RegCenterX = 3'd2;
  localparam logic [2:0] RegCenterY = 3'd3;
  localparam logic [2:0] RegBaseline = 3'd4;
  localparam logic [2:0] RegColorMode = 3'd5;

  // Accepted pixel handed from front to back
  typedef struct packed {
    logic [7:0]  sum;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pix_t;

  typedef struct packed {
    logic [15:0] focal_x;
    logic [15:0] focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [19:0] baseline;
    logic        color_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } bk_state_t;
endpackage

FILE: rtl/sdp_front.sv
// Front part: counters, right disparity window, consistency check.
module sdp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [6:0]       left_disp,
  input  logic [6:0]       right_disp,
  input  logic [7:0]       blue,
  input  logic [7:0]       green,
  input  logic [7:0]       red,
  input  logic             end_of_row,
  input  logic             end_of_frame,
  output logic             pix_valid,
  output sdp_pkg::pix_t    pix
);
  logic [6:0]  win_r [sdp_pkg::MaxDisp];
  logic [sdp_pkg::MaxDisp-1:0] wvalid_r;
  logic [11:0] col_r, row_r;
  logic [sdp_pkg::WinAw-1:0] widx, ridx;
  logic        vld_r, ok_r, hit_r;
  logic [6:0]  a_r, wd_r;
  logic [11:0] pcol_r, prow_r;
  logic [7:0]  b_r, g_r, red_r;
  logic [6:0]  rr;
  logic [7:0]  diffp, sum;
  logic        pass;

  assign widx = col_r[sdp_pkg::WinAw-1:0];
  assign ridx = widx - left_disp[sdp_pkg::WinAw-1:0];

  // window write; entry at col-a read into a register (the one being written only when a is zero)
  always_ff @(posedge clk) begin
    if (in_valid) win_r[widx] <= right_disp;
    wd_r <= win_r[ridx];
  end

  // Pixel stage register
  always_ff @(posedge clk) begin
    hit_r <= wvalid_r[ridx];
    ok_r <= (left_disp != 7'd0) && ({5'd0, left_disp} <= col_r)
        && ({25'd0, left_disp} < sdp_pkg::MaxDisp);
    a_r <= left_disp;
    pcol_r <= col_r;
    prow_r <= row_r;
    b_r <= blue;
    g_r <= green;
    red_r <= red;
  end

  assign rr = hit_r ? wd_r : 7'd0;
  assign diffp = {1'b0, a_r} - {1'b0, rr};
  assign sum = {1'b0, a_r} + {1'b0, rr};

  always_comb begin
    pass = ok_r && (diffp == 8'd0 || diffp == 8'd1 || diffp == 8'hFF) && (sum >= 8'd2);
  end

  assign pix_valid = vld_r && pass;

  always_comb begin
    pix.sum = sum;
    pix.col = pcol_r;
    pix.row = prow_r;
    pix.blue = b_r;
    pix.green = g_r;
    pix.red = red_r;
  end

  // Counters and window valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      wvalid_r <= '0;
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_valid;
      if (in_valid) begin
        wvalid_r[widx] <= 1'b1;
        if (end_of_frame) begin
          col_r <= '0;
          row_r <= '0;
        end else if (end_of_row) begin
          col_r <= '0;
          row_r <= row_r + 12'd1;
        end else begin
          col_r <= col_r + 12'd1;
        end
      end
    end
  end
endmodule

FILE: rtl/sdp_queue.sv
// Short queue between front and back parts.
module sdp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  sdp_pkg::pix_t wr_data,
  input  logic          rd_en,
  output logic          nempty,
  output sdp_pkg::pix_t rd_data,
  output logic [sdp_pkg::QAw:0] count
);
  sdp_pkg::pix_t mem_r [sdp_pkg::QDepth];
  logic [sdp_pkg::QAw-1:0] wp_r, rp_r;
  logic [sdp_pkg::QAw:0] cnt_r;

  assign nempty = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{sdp_pkg::QAw{1'b0}}, wr_en} - {{sdp_pkg::QAw{1'b0}}, rd_en};
    end
  end
endmodule

FILE: rtl/sdp_back.sv
// Back part: multiplies, then one shared radix-2 divider for z, x and y.
module sdp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sdp_pkg::cfg_t cfg,
  input  logic          q_nempty,
  input  sdp_pkg::pix_t q_data,
  output logic          q_pop,
  input  logic          res_full,
  output logic          res_push,
  output logic [31:0]   res_x,
  output logic [31:0]   res_y,
  output logic [30:0]   res_z,
  output logic [7:0]    res_b,
  output logic [7:0]    res_g,
  output logic [7:0]    res_r,
  output logic          res_sat
);
  sdp_pkg::bk_state_t st_r, st_nxt;
  sdp_pkg::pix_t px_r;
  logic [1:0]  job_r;
  logic [6:0]  step_r;
  logic [sdp_pkg::DivW-1:0] nx_r, ny_r;
  logic        xneg_r, yneg_r;
  logic [sdp_pkg::DivW-1:0] num_r, quo_r, rem_r, den_r;
  logic [sdp_pkg::DivW-1:0] qz_r, qx_r, qy_r;
  logic [sdp_pkg::DivW:0]   trial;
  logic [sdp_pkg::DivW-1:0] rem_sh;
  logic [16:0]   dx, dy;
  logic [16:0]   adx, ady;
  logic [36:0]   mz_r, mx_r, my_r;
  logic [15:0]   fy;
  logic [26:0]   dprod;
  logic [sdp_pkg::DivW-1:0] den_s, den_y;

  // offsets taken from the item being popped
  assign dx = {1'b0, q_data.col, 4'd0} - {1'b0, cfg.center_x};
  assign dy = {1'b0, q_data.row, 4'd0} - {1'b0, cfg.center_y};
  assign adx = dx[16] ? -dx : dx;
  assign ady = dy[16] ? -dy : dy;
  assign fy = (cfg.focal_y == 16'd0) ? 16'd1 : cfg.focal_y;
  assign dprod = {16'd0, px_r.sum, 3'd0} * {11'd0, fy};
  assign den_s = {53'd0, px_r.sum, 3'd0};
  assign den_y = {37'd0, dprod};
  assign rem_sh = {rem_r[sdp_pkg::DivW-2:0], num_r[sdp_pkg::DivW-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= sdp_pkg::BK_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    res_push = 1'b0;
    unique case (st_r)
      sdp_pkg::BK_IDLE: if (q_nempty) begin
        q_pop = 1'b1;
        st_nxt = sdp_pkg::BK_MUL;
      end
      sdp_pkg::BK_MUL: st_nxt = sdp_pkg::BK_DIV;
      sdp_pkg::BK_DIV: if (step_r == 7'd63 && job_r == 2'd2) st_nxt = sdp_pkg::BK_OUT;
      sdp_pkg::BK_OUT: if (!res_full) begin
        res_push = 1'b1;
        st_nxt = sdp_pkg::BK_IDLE;
      end
      default: st_nxt = sdp_pkg::BK_IDLE;
    endcase
  end

  // Products: x and first y product at pop, z product every cycle, second y product done in MUL stage
  always_ff @(posedge clk) begin
    if (q_pop) begin
      px_r <= q_data;
      mx_r <= {20'd0, adx} * {17'd0, cfg.baseline};
      my_r <= {20'd0, ady} * {21'd0, cfg.focal_x};
      xneg_r <= dx[16];
      yneg_r <= dy[16];
    end
    mz_r <= {21'd0, cfg.focal_x} * {17'd0, cfg.baseline};
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      sdp_pkg::BK_MUL: begin
        nx_r <= {27'd0, mx_r};
        ny_r <= {31'd0, my_r[32:0]} * {44'd0, cfg.baseline};
        num_r <= {27'd0, mz_r};
        den_r <= den_s;
        rem_r <= '0;
        quo_r <= '0;
        job_r <= 2'd0;
        step_r <= '0;
      end
      sdp_pkg::BK_DIV: begin
        if (step_r == 7'd63) begin
          // last step: store quotient; after z and x, load next job
          step_r <= '0;
          rem_r <= '0;
          quo_r <= '0;
          job_r <= job_r + 2'd1;
          unique case (job_r)
            2'd0: begin
              qz_r <= {quo_r[sdp_pkg::DivW-2:0], ~trial[sdp_pkg::DivW]};
              num_r <= nx_r;
              den_r <= den_s;
            end
            2'd1: begin
              qx_r <= {quo_r[sdp_pkg::DivW-2:0], ~trial[sdp_pkg::DivW]};
              num_r <= ny_r;
              den_r <= den_y;
            end
            default: qy_r <= {quo_r[sdp_pkg::DivW-2:0], ~trial[sdp_pkg::DivW]};
          endcase
        end else begin
          num_r <= {num_r[sdp_pkg::DivW-2:0], 1'b0};
          step_r <= step_r + 7'd1;
          if (!trial[sdp_pkg::DivW]) begin
            rem_r <= trial[sdp_pkg::DivW-1:0];
            quo_r <= {quo_r[sdp_pkg::DivW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[sdp_pkg::DivW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // Saturation and output mapping
  always_comb begin
    res_sat = qz_r > 64'd2147483647;
    res_z = res_sat ? 31'h7FFFFFFF : qz_r[30:0];
    if (xneg_r) res_x = (qx_r > 64'd2147483648) ? 32'h80000000 : -qx_r[31:0];
    else res_x = (qx_r > 64'd2147483647) ? 32'h7FFFFFFF : qx_r[31:0];
    if (yneg_r) res_y = (qy_r > 64'd2147483648) ? 32'h80000000 : -qy_r[31:0];
    else res_y = (qy_r > 64'd2147483647) ? 32'h7FFFFFFF : qy_r[31:0];
    res_b = px_r.blue;
    res_g = cfg.color_mode ? px_r.green : 8'd0;
    res_r = cfg.color_mode ? px_r.red : 8'd0;
  end
endmodule

FILE: rtl/stereo_disparity_to_point.sv
// Top level: config registers, front, queue, back and result register.
// The divider runs 3 x 64 steps per point, one job each for z, x and y.
// The shared bit-serial divider limits throughput; the back takes a new point only once the last is pushed.
// Dropped pixels are accepted like others; full rises while the queue has at most one free entry.
// Reset (rst_n low, synchronous) clears counters, window valid bits, the queue and the result valid flag.
// Registers return to their reset values.
module stereo_disparity_to_point (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [6:0]  in_left_disp,
  input  logic [6:0]  in_right_disp,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  input  logic        in_end_of_row,
  input  logic        in_end_of_frame,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [30:0] out_pos_z,
  output logic [7:0]  out_out_blue,
  output logic [7:0]  out_out_green,
  output logic [7:0]  out_out_red,
  output logic        out_z_saturated,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  sdp_pkg::cfg_t cfg_r;
  logic [2:0] ridx;
  logic acc, pix_valid, q_nempty, q_pop, res_push;
  sdp_pkg::pix_t pix, q_data;
  logic [sdp_pkg::QAw:0] q_count;
  logic [31:0] rx, ry;
  logic [30:0] rz;
  logic [7:0] rb, rg, rr;
  logic rs, ov_r;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];

  // Config register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x <= 16'd11200;
      cfg_r.focal_y <= 16'd11200;
      cfg_r.center_x <= 16'd5120;
      cfg_r.center_y <= 16'd3840;
      cfg_r.baseline <= 20'd120000;
      cfg_r.color_mode <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        sdp_pkg::RegFocalX: cfg_r.focal_x <= cfg_pwdata[15:0];
        sdp_pkg::RegFocalY: cfg_r.focal_y <= cfg_pwdata[15:0];
        sdp_pkg::RegCenterX: cfg_r.center_x <= cfg_pwdata[15:0];
        sdp_pkg::RegCenterY: cfg_r.center_y <= cfg_pwdata[15:0];
        sdp_pkg::RegBaseline: cfg_r.baseline <= cfg_pwdata[19:0];
        sdp_pkg::RegColorMode: cfg_r.color_mode <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      sdp_pkg::RegFocalX: cfg_prdata = {16'd0, cfg_r.focal_x};
      sdp_pkg::RegFocalY: cfg_prdata = {16'd0, cfg_r.focal_y};
      sdp_pkg::RegCenterX: cfg_prdata = {16'd0, cfg_r.center_x};
      sdp_pkg::RegCenterY: cfg_prdata = {16'd0, cfg_r.center_y};
      sdp_pkg::RegBaseline: cfg_prdata = {12'd0, cfg_r.baseline};
      sdp_pkg::RegColorMode: cfg_prdata = {31'd0, cfg_r.color_mode};
      default: cfg_prdata = '0;
    endcase
  end

  // keep room for the item in the front register
  assign in_full = q_count >= (sdp_pkg::QAw+1)'(sdp_pkg::QDepth - 1);
  assign acc = in_push && !in_full;

  sdp_front u_front (
    .clk, .rst_n, .in_valid(acc), .left_disp(in_left_disp), .right_disp(in_right_disp),
    .blue(in_blue), .green(in_green), .red(in_red), .end_of_row(in_end_of_row),
    .end_of_frame(in_end_of_frame), .pix_valid, .pix
  );

  sdp_queue u_queue (
    .clk, .rst_n, .wr_en(pix_valid), .wr_data(pix), .rd_en(q_pop),
    .nempty(q_nempty), .rd_data(q_data), .count(q_count)
  );

  sdp_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_nempty, .q_data, .q_pop, .res_full(ov_r),
    .res_push, .res_x(rx), .res_y(ry), .res_z(rz), .res_b(rb), .res_g(rg),
    .res_r(rr), .res_sat(rs)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (res_push) ov_r <= 1'b1;
    else if (out_pop) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_pos_x <= rx;
      out_pos_y <= ry;
      out_pos_z <= rz;
      out_out_blue <= rb;
      out_out_green <= rg;
      out_out_red <= rr;
      out_z_saturated <= rs;
    end
  end

  assign out_empty = !ov_r;
endmodule

FILE: rtl/sdp_checker.sv
// Port-level checker for the stereo disparity to point block, with bind.
module sdp_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [30:0] out_pos_z,
  input logic        out_z_saturated,
  input logic        cfg_pready
);
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_z_saturated |-> out_pos_z == 31'h7FFFFFFF) else $error("sat z");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_pos_z)) else $error("hold");
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty) else $error("rst");
  a_ready: assert property (@(posedge clk) cfg_pready) else $error("pready");
endmodule

bind stereo_disparity_to_point sdp_port_props u_chk (
  .clk, .rst_n, .out_empty, .out_pop, .out_pos_z, .out_z_saturated, .cfg_pready
);

FILE: tb/sdp_checker.sv
// Checker for stereo_disparity_to_point: predicts points from accepted pixels and compares.
`timescale 1ns / 1ps
module sdp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [6:0]  in_left_disp,
  input  logic [6:0]  in_right_disp,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  input  logic        in_end_of_row,
  input  logic        in_end_of_frame,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [31:0] out_pos_x,
  input  logic [31:0] out_pos_y,
  input  logic [30:0] out_pos_z,
  input  logic [7:0]  out_out_blue,
  input  logic [7:0]  out_out_green,
  input  logic [7:0]  out_out_red,
  input  logic        out_z_saturated,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          points_waiting,
  output int          points_checked
);
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] z;
    logic [7:0]  b;
    logic [7:0]  g;
    logic [7:0]  r;
    logic        sat;
  } point_t;

  point_t         point_q[$];
  sdp_pkg::cfg_t  cam;
  logic [6:0]     rdisp_hist [sdp_pkg::MaxDisp];
  logic [11:0]    col_cnt;
  logic [11:0]    row_cnt;

  initial begin
    fail_count = 0;
    points_checked = 0;
    points_waiting = 0;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Consistency check and back-projection for one pixel at the current counts
  function automatic bit project_pixel(input logic [6:0] a, input logic [7:0] b,
                                       input logic [7:0] g, input logic [7:0] r,
                                       output point_t p);
    longint rr, s, den, zq, fy, xn, yn, bl, fx;
    if (a == 0 || a > col_cnt) return 0;
    rr = rdisp_hist[(col_cnt - a) % sdp_pkg::MaxDisp];
    s = a + rr;
    if ((a > rr ? a - rr : rr - a) > 1 || s < 2) return 0;
    den = 8 * s;
    bl = cam.baseline;
    fx = cam.focal_x;
    fy = (cam.focal_y == 0) ? 1 : cam.focal_y;
    zq = fx * bl / den;
    xn = (16 * longint'(col_cnt) - longint'(cam.center_x)) * bl;
    yn = (16 * longint'(row_cnt) - longint'(cam.center_y)) * fx * bl;
    p.x = 32'(sat32(xn / den));
    p.y = 32'(sat32(yn / (den * fy)));
    p.sat = zq > 64'sd2147483647;
    p.z = p.sat ? 31'h7fffffff : zq[30:0];
    p.b = b;
    p.g = cam.color_mode ? g : 8'd0;
    p.r = cam.color_mode ? r : 8'd0;
    return 1;
  endfunction

  always @(posedge clk) begin
    point_t p, w;
    if (!rst_n) begin
      cam.focal_x <= 16'd11200;
      cam.focal_y <= 16'd11200;
      cam.center_x <= 16'd5120;
      cam.center_y <= 16'd3840;
      cam.baseline <= 20'd120000;
      cam.color_mode <= 1'b1;
      col_cnt <= '0;
      row_cnt <= '0;
      for (int i = 0; i < sdp_pkg::MaxDisp; i++) rdisp_hist[i] <= '0;
      point_q.delete();
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          sdp_pkg::RegFocalX:    cam.focal_x <= cfg_pwdata[15:0];
          sdp_pkg::RegFocalY:    cam.focal_y <= cfg_pwdata[15:0];
          sdp_pkg::RegCenterX:   cam.center_x <= cfg_pwdata[15:0];
          sdp_pkg::RegCenterY:   cam.center_y <= cfg_pwdata[15:0];
          sdp_pkg::RegBaseline:  cam.baseline <= cfg_pwdata[19:0];
          sdp_pkg::RegColorMode: cam.color_mode <= cfg_pwdata[0];
          default: ;
        endcase
      end
      // accepted pixel: store right disparity first, then predict
      if (in_push && !in_full) begin
        rdisp_hist[col_cnt % sdp_pkg::MaxDisp] = in_right_disp;
        if (project_pixel(in_left_disp, in_blue, in_green, in_red, p))
          point_q.insert(point_q.size(), p);
        if (in_end_of_frame) begin
          col_cnt <= '0;
          row_cnt <= '0;
        end else if (in_end_of_row) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + 12'd1;
        end else begin
          col_cnt <= col_cnt + 12'd1;
        end
      end
      // accepted point
      if (out_pop && !out_empty) begin
        if (point_q.size() == 0) begin
          report("unexpected point, pos_z", out_pos_z, 0);
        end else begin
          w = point_q[0];
          point_q.delete(0);
          points_checked++;
          if (out_pos_x !== w.x) report("pos_x", $signed(out_pos_x), $signed(w.x));
          if (out_pos_y !== w.y) report("pos_y", $signed(out_pos_y), $signed(w.y));
          if (out_pos_z !== w.z) report("pos_z", out_pos_z, w.z);
          if (out_out_blue !== w.b) report("out_blue", out_out_blue, w.b);
          if (out_out_green !== w.g) report("out_green", out_out_green, w.g);
          if (out_out_red !== w.r) report("out_red", out_out_red, w.r);
          if (out_z_saturated !== w.sat) report("z_saturated", out_z_saturated, w.sat);
        end
      end
    end
    points_waiting = point_q.size();
  end
endmodule

FILE: tb/stereo_disparity_to_point_tb.sv
// Testbench top for stereo_disparity_to_point: pixel stimulus, register phases and verdict.
`timescale 1ns / 1ps
module stereo_disparity_to_point_tb;
  localparam int CycleLimit = 1200000;
  localparam int DrainWait = 250;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_push = 0;
  logic        in_full;
  logic [6:0]  in_left_disp = 0;
  logic [6:0]  in_right_disp = 0;
  logic [7:0]  in_blue = 0;
  logic [7:0]  in_green = 0;
  logic [7:0]  in_red = 0;
  logic        in_end_of_row = 0;
  logic        in_end_of_frame = 0;
  logic        out_empty;
  logic        out_pop = 0;
  logic [31:0] out_pos_x;
  logic [31:0] out_pos_y;
  logic [30:0] out_pos_z;
  logic [7:0]  out_out_blue;
  logic [7:0]  out_out_green;
  logic [7:0]  out_out_red;
  logic        out_z_saturated;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [4:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count, points_waiting, points_checked;
  int pixels_sent = 0;
  int cycles = 0;
  bit quiet = 0;
  bit hold_req = 0;
  bit hold_done = 0;

  always #5 clk = ~clk;

  stereo_disparity_to_point uut (.*);
  sdp_checker chk (.*);

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // point receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_pop <= 0;
        repeat (3000) @(posedge clk);
        hold_done = 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_pop <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_pop <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_pixel(input logic [6:0] a, input logic [6:0] rd, input bit eor,
                            input bit eof);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_push <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_push <= 1;
    in_left_disp <= a;
    in_right_disp <= rd;
    in_blue <= 8'($urandom);
    in_green <= 8'($urandom);
    in_red <= 8'($urandom);
    in_end_of_row <= eor;
    in_end_of_frame <= eof;
    do @(posedge clk); while (in_full);
    pixels_sent++;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  // let the block finish before touching registers
  task automatic drain;
    in_push <= 0;
    @(posedge clk);
    while (points_waiting != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic set_camera(input logic [15:0] fx, input logic [15:0] fy,
                            input logic [15:0] cx, input logic [15:0] cy,
                            input logic [19:0] bl, input bit mode);
    drain();
    reg_write(sdp_pkg::RegFocalX, {16'd0, fx});
    reg_write(sdp_pkg::RegFocalY, {16'd0, fy});
    reg_write(sdp_pkg::RegCenterX, {16'd0, cx});
    reg_write(sdp_pkg::RegCenterY, {16'd0, cy});
    reg_write(sdp_pkg::RegBaseline, {12'd0, bl});
    reg_write(sdp_pkg::RegColorMode, {31'd0, mode});
  endtask

  // rows with a constant right disparity and left disparities near it, plus noise rows
  task automatic random_rows(input int n_pix);
    int stop, w, d, k;
    logic [6:0] a, rd;
    bit eof;
    stop = pixels_sent + n_pix;
    while (pixels_sent < stop) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 20))
          send_pixel(7'($urandom), 7'($urandom), $urandom_range(0, 7) == 0,
                     $urandom_range(0, 15) == 0);
      end else begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 260) : $urandom_range(4, 60);
        d = $urandom_range(1, (w > 127) ? 127 : w - 1);
        eof = $urandom_range(0, 3) == 0;
        for (int c = 0; c < w; c++) begin
          rd = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'(d);
          k = $urandom_range(0, 9);
          if (k <= 5) a = 7'((d + $urandom_range(0, 2) - 1 > 127) ? 127 : d + $urandom_range(0, 2) - 1);
          else if (k == 6) a = 0;
          else a = 7'($urandom);
          send_pixel(a, rd, c == w - 1, (c == w - 1) && eof);
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed row under reset registers
    send_pixel(0, 1, 0, 0);      // no disparity
    send_pixel(1, 1, 0, 0);      // match, smallest sum
    send_pixel(2, 3, 0, 0);      // differs by one
    send_pixel(2, 1, 0, 0);      // differs by one again
    send_pixel(9, 0, 0, 0);      // disparity beyond column
    send_pixel(1, 5, 0, 0);      // differs by one, sum below two
    send_pixel(1, 127, 0, 0);
    send_pixel(2, 0, 0, 0);      // stored five against two
    send_pixel(127, 127, 1, 0);  // end of row
    send_pixel(0, 2, 0, 0);
    send_pixel(1, 1, 0, 0);      // differs by one on second row
    send_pixel(1, 1, 1, 1);      // both marks, frame wins
    send_pixel(0, 0, 0, 0);
    send_pixel(1, 0, 0, 1);      // end of frame alone

    // widest range: depth saturates, lateral clamps
    set_camera(16'hffff, 16'd1, 16'd0, 16'd0, 20'd1000000, 1);
    for (int c = 0; c < 6; c++) send_pixel(c == 0 ? 0 : 1, 1, 0, 0);
    random_rows(240);

    // smallest focal and baseline, largest centre, zero vertical focal length, grey pixels
    set_camera(16'd1, 16'd0, 16'hffff, 16'hffff, 20'd1, 0);
    random_rows(250);

    // reset values again while the receiver holds off
    set_camera(16'd11200, 16'd11200, 16'd5120, 16'd3840, 20'd120000, 1);
    hold_req = 1;
    random_rows(250);
    while (!hold_done) @(posedge clk);

    repeat (2) begin
      set_camera(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
                 16'($urandom), 20'($urandom_range(1, 1000000)),
                 1'($urandom_range(0, 1)));
      random_rows(230);
    end

    // no idling at the end
    set_camera(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
               16'($urandom), 16'($urandom), 20'($urandom_range(1, 1000000)), 1);
    quiet = 1;
    random_rows(200);
    drain();

    $display("%0d pixels sent over six register settings, %0d points checked",
             pixels_sent, points_checked);
    $display("covered saturation, grey mode, zero focal, row and frame marks, input stall");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
